>>> rtl/dmp_pkg.sv
// shared constants, opcode codes and seed scramble functions for the dual-mode prng
`default_nettype none
package dmp_pkg;

  localparam logic [63:0] SEED_RESET = 64'hab8d9f7781280783;
  localparam logic [63:0] XS_MULT    = 64'h2545f4914f6cdd1d;

  typedef enum logic [1:0] {
    OP_NEXT     = 2'd0,
    OP_RESEED   = 2'd1,
    OP_SCRAMBLE = 2'd2
  } opcode_t;

  function automatic logic [63:0] legacy_scramble(input logic [63:0] s);
    logic [63:0] t;
    t = (((s << 63) >> 31) | ((s << 31) >> 32)) ^ ((s << 44) >> 32);
    return ((t >> 20) & 64'h0000_0000_0000_0fff) ^ t;
  endfunction

  function automatic logic [63:0] xorshift_advance(input logic [63:0] s);
    logic [63:0] x;
    x = s ^ (s >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    return x;
  endfunction

endpackage
`default_nettype wire

>>> rtl/dmp_mul_hi.sv
// bits 63:32 of seed times the xorshift multiplier, from registered 32x32 partial products
`default_nettype none
module dmp_mul_hi
  import dmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        ld,
  input  wire logic [63:0] x,
  output logic      [31:0] hi
);

  logic [63:0] p_ll_r;
  logic [31:0] p_hl_r;
  logic [31:0] p_lh_r;
  logic [63:0] p_ll_nxt;
  logic [63:0] p_hl_nxt;
  logic [63:0] p_lh_nxt;

  always_comb begin
    p_ll_nxt = {32'd0, x[31:0]}  * {32'd0, XS_MULT[31:0]};
    p_hl_nxt = {32'd0, x[63:32]} * {32'd0, XS_MULT[31:0]};
    p_lh_nxt = {32'd0, x[31:0]}  * {32'd0, XS_MULT[63:32]};
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      p_ll_r <= p_ll_nxt;
      p_hl_r <= p_hl_nxt[31:0];
      p_lh_r <= p_lh_nxt[31:0];
    end
  end

  // cross terms only reach the upper half through their low 32 bits
  assign hi = p_ll_r[63:32] + p_hl_r + p_lh_r;

endmodule
`default_nettype wire

>>> rtl/dual_mode_prng_xorshift64star.sv
// top level of the dual-mode 64-bit prng with one seed register
// The block takes one word per clock while in_ready is high and returns one result word
// for each via the stage 1, stage 2 and output registers. The seed register is updated in
// the accept cycle (xorshift64* or legacy scramble as chosen by cfg_wdata, or reseed to
// seed_value plus one), so words may follow each other back to back; the xorshift64*
// output multiply runs in the two pipeline stages after the seed update as three 32x32
// partial products and a final add. Each stage holds its word while the next is full, so
// input is still taken while a result waits at the output. Opcode 3 returns zero and the
// current seed without changing it.
`default_nettype none
module dual_mode_prng_xorshift64star
  import dmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [63:0] in_seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] out_random_value,
  output logic      [63:0] out_seed_out
);

  logic        use_xorshift_r;
  logic [63:0] seed_r;
  logic [63:0] seed_nxt;

  logic        v1_r;
  logic        mul1_r;
  logic [31:0] rnd1_r;
  logic [63:0] sout1_r;
  logic        mul1_nxt;
  logic [31:0] rnd1_nxt;
  logic [63:0] sout1_nxt;

  logic        v2_r;
  logic        mul2_r;
  logic [31:0] rnd2_r;
  logic [63:0] sout2_r;

  logic        ov_r;
  logic [31:0] orand_r;
  logic [63:0] oseed_r;

  logic        ready_o;
  logic        ready_2;
  logic        ready_1;
  logic        accept;
  logic        adv_2;
  logic        adv_o;
  logic [31:0] mul_hi;
  logic [63:0] scr;

  assign ready_o = !ov_r || out_ready;
  assign ready_2 = !v2_r || ready_o;
  assign ready_1 = !v1_r || ready_2;
  assign in_ready = ready_1;
  assign accept = in_valid && ready_1;
  assign adv_2 = v1_r && ready_2;
  assign adv_o = v2_r && ready_o;

  always_comb begin
    seed_nxt  = seed_r;
    mul1_nxt  = 1'b0;
    rnd1_nxt  = 32'd0;
    sout1_nxt = seed_r;
    scr       = legacy_scramble(in_seed_value);
    case (in_opcode)
      OP_NEXT: begin
        if (use_xorshift_r) begin
          seed_nxt = xorshift_advance(seed_r);
          mul1_nxt = 1'b1;
        end else begin
          seed_nxt = legacy_scramble(seed_r);
          rnd1_nxt = seed_nxt[31:0];
        end
        sout1_nxt = seed_nxt;
      end
      OP_RESEED: begin
        seed_nxt  = in_seed_value + 64'd1;
        sout1_nxt = seed_nxt;
      end
      OP_SCRAMBLE: begin
        sout1_nxt = scr;
        rnd1_nxt  = scr[31:0];
      end
      default: begin
        sout1_nxt = seed_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_xorshift_r <= 1'b1;
      seed_r         <= SEED_RESET;
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      ov_r           <= 1'b0;
    end else begin
      if (cfg_we) begin
        use_xorshift_r <= cfg_wdata;
      end
      if (accept) begin
        seed_r <= seed_nxt;
      end
      if (ready_1) begin
        v1_r <= in_valid;
      end
      if (ready_2) begin
        v2_r <= v1_r;
      end
      if (ready_o) begin
        ov_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mul1_r  <= mul1_nxt;
      rnd1_r  <= rnd1_nxt;
      sout1_r <= sout1_nxt;
    end
    if (adv_2) begin
      mul2_r  <= mul1_r;
      rnd2_r  <= rnd1_r;
      sout2_r <= sout1_r;
    end
    if (adv_o) begin
      orand_r <= mul2_r ? mul_hi : rnd2_r;
      oseed_r <= sout2_r;
    end
  end

  dmp_mul_hi u_mul_hi (
    .clk (clk),
    .ld  (adv_2),
    .x   (sout1_r),
    .hi  (mul_hi)
  );

  assign out_valid        = ov_r;
  assign out_random_value = orand_r;
  assign out_seed_out     = oseed_r;

endmodule
`default_nettype wire
